FILE: sv/agd_pkg.sv
// Shared types and constants for the access gate decision block.
package agd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned IDX_W  = 3;

  localparam logic [TIME_W-1:0] GAP_GRACE_MS = TIME_W'(300);

  // Config register indexes
  localparam logic [IDX_W-1:0] CFG_IDLE_RESET     = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_UNK_THROTTLE   = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_OPEN_HOLD      = IDX_W'(2);
  localparam logic [IDX_W-1:0] CFG_DENY_COOLDOWN  = IDX_W'(3);
  localparam logic [IDX_W-1:0] CFG_STABILIZE      = IDX_W'(4);

  // Config reset values
  localparam logic [TIME_W-1:0] RST_IDLE_RESET    = TIME_W'(10000);
  localparam logic [TIME_W-1:0] RST_UNK_THROTTLE  = TIME_W'(5000);
  localparam logic [TIME_W-1:0] RST_OPEN_HOLD     = TIME_W'(3000);
  localparam logic [TIME_W-1:0] RST_DENY_COOLDOWN = TIME_W'(2000);
  localparam logic [TIME_W-1:0] RST_STABILIZE     = TIME_W'(0);

  typedef enum logic [2:0] {
    OUT_BLOCKED     = 3'd0,
    OUT_NOFACE      = 3'd1,
    OUT_STABILIZING = 3'd2,
    OUT_FAULT       = 3'd3,
    OUT_SILENT      = 3'd4,
    OUT_GRANT       = 3'd5,
    OUT_DENY        = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    DEC_NONE    = 2'd0,
    DEC_GRANTED = 2'd1,
    DEC_UNKNOWN = 2'd2
  } decision_e;

  typedef struct packed {
    logic [TIME_W-1:0] idle_reset_ms;
    logic [TIME_W-1:0] unknown_throttle_ms;
    logic [TIME_W-1:0] grant_hold_ms;
    logic [TIME_W-1:0] deny_hold_ms;
    logic [TIME_W-1:0] stabilize_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              face_present;
    logic              embed_ok;
    logic              matched;
    logic [ID_W-1:0]   employee_id;
    logic [ID_W-1:0]   match_distance;
  } in_item_t;

  typedef struct packed {
    outcome_e        outcome;
    logic            emit_event;
    logic            open_gate;
    logic            sound_deny;
    logic [ID_W-1:0] event_employee;
    logic [ID_W-1:0] event_distance;
  } result_t;

endpackage

FILE: sv/agd_if.sv
// Handshake channel interfaces: frame verdicts, decisions, config writes.
interface agd_in_if;
  logic                        valid;
  logic                        ready;
  logic [agd_pkg::TIME_W-1:0]  time_ms;
  logic                        face_present;
  logic                        embed_ok;
  logic                        matched;
  logic [agd_pkg::ID_W-1:0]    employee_id;
  logic [agd_pkg::ID_W-1:0]    match_distance;

  modport source (output valid, time_ms, face_present, embed_ok, matched,
                  employee_id, match_distance, input ready);
  modport sink (input valid, time_ms, face_present, embed_ok, matched,
                employee_id, match_distance, output ready);
endinterface

interface agd_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                outcome;
  logic                      emit_event;
  logic                      open_gate;
  logic                      sound_deny;
  logic [agd_pkg::ID_W-1:0]  event_employee;
  logic [agd_pkg::ID_W-1:0]  event_distance;

  modport source (output valid, outcome, emit_event, open_gate, sound_deny,
                  event_employee, event_distance, input ready);
  modport sink (input valid, outcome, emit_event, open_gate, sound_deny,
                event_employee, event_distance, output ready);
endinterface

interface agd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [agd_pkg::IDX_W-1:0]   index;
  logic [agd_pkg::TIME_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/agd_cfg_regs.sv
// Configuration register file with reset defaults.
module agd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  agd_cfg_if.sink       cfg_if,
  output agd_pkg::cfg_t cfg_o
);
  import agd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_IDLE_RESET:    cfg_d.idle_reset_ms       = cfg_if.data;
        CFG_UNK_THROTTLE:  cfg_d.unknown_throttle_ms = cfg_if.data;
        CFG_OPEN_HOLD:     cfg_d.grant_hold_ms       = cfg_if.data;
        CFG_DENY_COOLDOWN: cfg_d.deny_hold_ms        = cfg_if.data;
        CFG_STABILIZE:     cfg_d.stabilize_ms        = cfg_if.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_reset_ms       <= RST_IDLE_RESET;
      cfg_q.unknown_throttle_ms <= RST_UNK_THROTTLE;
      cfg_q.grant_hold_ms       <= RST_OPEN_HOLD;
      cfg_q.deny_hold_ms        <= RST_DENY_COOLDOWN;
      cfg_q.stabilize_ms        <= RST_STABILIZE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/agd_decide.sv
// Decision logic and gate state: one frame verdict resolved per step.
module agd_decide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  agd_pkg::in_item_t item_i,
  input  agd_pkg::cfg_t     cfg_i,
  output agd_pkg::result_t  result_o
);
  import agd_pkg::*;

  logic              block_active_q, block_active_d;
  logic [TIME_W-1:0] block_end_q, block_end_d;
  logic              streak_valid_q, streak_valid_d;
  logic [TIME_W-1:0] streak_begin_q, streak_begin_d;
  logic [TIME_W-1:0] last_detection_q, last_detection_d;
  decision_e         decision_q, decision_d;
  logic [ID_W-1:0]   decided_employee_q, decided_employee_d;
  logic              face_ever_seen_q, face_ever_seen_d;
  logic [TIME_W-1:0] last_face_time_q, last_face_time_d;
  logic [TIME_W-1:0] last_deny_time_q, last_deny_time_d;

  logic [TIME_W-1:0] t;
  logic [TIME_W-1:0] since_block, since_detect, since_begin, since_face, since_deny;
  logic              blocked, restart, stabilizing, idle_gap;
  decision_e         dec_eff;
  logic [ID_W-1:0]   emp_eff;
  result_t           res;

  assign t            = item_i.time_ms;
  assign since_block  = t - block_end_q;
  assign since_detect = t - last_detection_q;
  assign since_face   = t - last_face_time_q;
  assign since_deny   = t - last_deny_time_q;

  // block_end ahead by 1 to 2^31 ms means still blocked
  assign blocked     = block_active_q && since_block[TIME_W-1];
  assign restart     = !streak_valid_q || (since_detect > GAP_GRACE_MS);
  assign since_begin = restart ? '0 : (t - streak_begin_q);
  assign stabilizing = (cfg_i.stabilize_ms != '0) && (since_begin < cfg_i.stabilize_ms);
  assign idle_gap    = face_ever_seen_q && (since_face > cfg_i.idle_reset_ms);
  assign dec_eff     = idle_gap ? DEC_NONE : decision_q;
  assign emp_eff     = idle_gap ? '0 : decided_employee_q;

  always_comb begin
    block_active_d     = block_active_q;
    block_end_d        = block_end_q;
    streak_valid_d     = streak_valid_q;
    streak_begin_d     = streak_begin_q;
    last_detection_d   = last_detection_q;
    decision_d         = decision_q;
    decided_employee_d = decided_employee_q;
    face_ever_seen_d   = face_ever_seen_q;
    last_face_time_d   = last_face_time_q;
    last_deny_time_d   = last_deny_time_q;

    res = '{outcome: OUT_BLOCKED, emit_event: 1'b0, open_gate: 1'b0,
            sound_deny: 1'b0, event_employee: '0, event_distance: '0};

    if (!blocked) begin
      block_active_d = 1'b0;
      if (!item_i.face_present) begin
        res.outcome = OUT_NOFACE;
      end else begin
        streak_valid_d   = 1'b1;
        last_detection_d = t;
        if (restart) begin
          streak_begin_d = t;
        end
        if (stabilizing) begin
          res.outcome = OUT_STABILIZING;
        end else if (!item_i.embed_ok) begin
          res.outcome    = OUT_FAULT;
          res.emit_event = 1'b1;
        end else begin
          decision_d         = dec_eff;
          decided_employee_d = emp_eff;
          last_face_time_d   = t;
          face_ever_seen_d   = 1'b1;
          res.outcome        = OUT_SILENT;
          if (item_i.matched) begin
            if (dec_eff != DEC_GRANTED || emp_eff != item_i.employee_id) begin
              block_end_d        = t + cfg_i.grant_hold_ms;
              block_active_d     = 1'b1;
              decision_d         = DEC_GRANTED;
              decided_employee_d = item_i.employee_id;
              res.outcome        = OUT_GRANT;
              res.emit_event     = 1'b1;
              res.open_gate      = 1'b1;
              res.event_employee = item_i.employee_id;
              res.event_distance = item_i.match_distance;
            end
          end else if (dec_eff != DEC_UNKNOWN || since_deny >= cfg_i.unknown_throttle_ms) begin
            block_end_d        = t + cfg_i.deny_hold_ms;
            block_active_d     = 1'b1;
            decision_d         = DEC_UNKNOWN;
            decided_employee_d = '0;
            last_deny_time_d   = t;
            res.outcome        = OUT_DENY;
            res.emit_event     = 1'b1;
            res.sound_deny     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_active_q     <= 1'b0;
      block_end_q        <= '0;
      streak_valid_q     <= 1'b0;
      streak_begin_q     <= '0;
      last_detection_q   <= '0;
      decision_q         <= DEC_NONE;
      decided_employee_q <= '0;
      face_ever_seen_q   <= 1'b0;
      last_face_time_q   <= '0;
      last_deny_time_q   <= '0;
    end else if (step_i) begin
      block_active_q     <= block_active_d;
      block_end_q        <= block_end_d;
      streak_valid_q     <= streak_valid_d;
      streak_begin_q     <= streak_begin_d;
      last_detection_q   <= last_detection_d;
      decision_q         <= decision_d;
      decided_employee_q <= decided_employee_d;
      face_ever_seen_q   <= face_ever_seen_d;
      last_face_time_q   <= last_face_time_d;
      last_deny_time_q   <= last_deny_time_d;
    end
  end

  assign result_o = res;

  // A grant or deny arms the block window
  a_event_arms_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.outcome == OUT_GRANT || res.outcome == OUT_DENY) |=> block_active_q)
    else $error("grant/deny did not arm block window");

  // A blocked step leaves the decision state untouched
  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && blocked |=> $stable(decision_q) && $stable(last_detection_q)
                          && $stable(block_end_q))
    else $error("blocked frame changed state");

  // Unknown decision never carries an employee
  a_unknown_no_emp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decision_q == DEC_UNKNOWN |-> decided_employee_q == '0)
    else $error("unknown decision holds an employee id");

  // A deny records its time as the last deny time
  a_deny_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.outcome == OUT_DENY |=> last_deny_time_q == $past(t))
    else $error("deny time not recorded");

endmodule

FILE: sv/access_gate_decision_fsm_core.sv
// Top level of the access gate decision block: input/output registers and handshakes.
//
//  channel  dir  role                          accepted when
//  in_if    in   frame verdict word            in_if.valid  && in_if.ready
//  out_if   out  decision word                 out_if.valid && out_if.ready
//  cfg_if   in   config write (index, data)    cfg_if.valid (ready tied high)
//
//  A word accepted into the input register moves on to the output register
//  when that register is free, and its decision word is then valid on
//  out_if; one word is taken per cycle while out_if drains. The decision
//  runs combinationally between the input register and the output
//  register and updates the gate state on the same edge, so the next word
//  sees it. Reset clears the valid flags, the gate state and loads config
//  defaults. If out_if stalls, the output register holds and the input
//  register takes one more word before in_if.ready drops.
module access_gate_decision_fsm_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  agd_in_if.sink   in_if,
  agd_out_if.source out_if,
  agd_cfg_if.sink  cfg_if
);
  import agd_pkg::*;

  cfg_t     cfg;
  in_item_t in_item_q;
  logic     in_valid_q, in_valid_d;
  result_t  res;
  result_t  out_item_q;
  logic     out_valid_q, out_valid_d;
  logic     advance;
  logic     in_accept;

  agd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // Word moves from input register to output register when the latter frees up
  assign advance      = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || advance;
  assign in_accept    = in_if.valid && in_if.ready;

  agd_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q.time_ms        <= in_if.time_ms;
      in_item_q.face_present   <= in_if.face_present;
      in_item_q.embed_ok       <= in_if.embed_ok;
      in_item_q.matched        <= in_if.matched;
      in_item_q.employee_id    <= in_if.employee_id;
      in_item_q.match_distance <= in_if.match_distance;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.outcome        = out_item_q.outcome;
  assign out_if.emit_event     = out_item_q.emit_event;
  assign out_if.open_gate      = out_item_q.open_gate;
  assign out_if.sound_deny     = out_item_q.sound_deny;
  assign out_if.event_employee = out_item_q.event_employee;
  assign out_if.event_distance = out_item_q.event_distance;

  // Output register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |-> !advance)
    else $error("decision word overwritten under stall");

  // A gate-opening word also emits an event and never sounds the deny
  a_grant_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_if.open_gate |-> out_if.emit_event && !out_if.sound_deny)
    else $error("grant word fields inconsistent");

  // An accepted word sets the input register valid flag
  a_in_reg_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_valid_q)
    else $error("accepted word lost");

endmodule
